[sv/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg
// shared types, constants and helper functions for the chacha20 keystream
// pipeline
// ----------------------------------------------------------------------------
package cc20_pkg;

  // default number of double rounds
  localparam int DOUBLE_ROUNDS_DEF = 10;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE  = 3'd4;

  // byte count range
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] BLOCK_BYTES = 7'd64;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;

  // per-item side data carried along the round pipeline
  typedef struct packed {
    logic             valid;
    logic [63:0]      ctr;
    logic [CNT_W-1:0] cnt;
  } meta_t;

  // "expand 32-byte k", word 0 in the low slot
  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  function automatic word_t rotl(input word_t x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // initial 4x4 state from constants, key, counter and nonce
  function automatic state_t init_state(input logic [63:0] k0,
                                        input logic [63:0] k1,
                                        input logic [63:0] k2,
                                        input logic [63:0] k3,
                                        input logic [63:0] ctr,
                                        input logic [63:0] nonce);
    state_t s;
    s[0]  = SIGMA[0];
    s[1]  = SIGMA[1];
    s[2]  = SIGMA[2];
    s[3]  = SIGMA[3];
    s[4]  = k0[31:0];
    s[5]  = k0[63:32];
    s[6]  = k1[31:0];
    s[7]  = k1[63:32];
    s[8]  = k2[31:0];
    s[9]  = k2[63:32];
    s[10] = k3[31:0];
    s[11] = k3[63:32];
    s[12] = ctr[31:0];
    s[13] = ctr[63:32];
    s[14] = nonce[31:0];
    s[15] = nonce[63:32];
    return s;
  endfunction

endpackage

[sv/cc20_round_stage.sv]
// ----------------------------------------------------------------------------
// cc20_round_stage
// one pipeline stage: half of a column or diagonal round, four quarter
// rounds side by side, two dependent add/xor/rotate steps each
// ----------------------------------------------------------------------------
module cc20_round_stage #(
  parameter bit DIAG   = 1'b0,
  parameter bit SECOND = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cc20_pkg::meta_t in_meta,
  input  cc20_pkg::state_t in_st,
  output cc20_pkg::meta_t out_meta,
  output cc20_pkg::state_t out_st
);

  localparam int ROT_D = SECOND ? 8 : 16;
  localparam int ROT_B = SECOND ? 7 : 12;

  cc20_pkg::state_t st_next;
  cc20_pkg::state_t st;
  logic             valid;
  logic [63:0]      ctr;
  logic [cc20_pkg::CNT_W-1:0] cnt;

  // four independent quarter-round halves
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    cc20_pkg::word_t a, b, c, d;
    st_next = in_st;
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = DIAG ? 4'(4 + ((q + 1) % 4))  : 4'(4 + q);
      ic = DIAG ? 4'(8 + ((q + 2) % 4))  : 4'(8 + q);
      id = DIAG ? 4'(12 + ((q + 3) % 4)) : 4'(12 + q);
      a = in_st[ia];
      b = in_st[ib];
      c = in_st[ic];
      d = in_st[id];
      a = a + b;
      d = cc20_pkg::rotl(d ^ a, ROT_D);
      c = c + d;
      b = cc20_pkg::rotl(b ^ c, ROT_B);
      st_next[ia] = a;
      st_next[ib] = b;
      st_next[ic] = c;
      st_next[id] = d;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_meta.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      st  <= st_next;
      ctr <= in_meta.ctr;
      cnt <= in_meta.cnt;
    end
  end

  assign out_st         = st;
  assign out_meta.valid = valid;
  assign out_meta.ctr   = ctr;
  assign out_meta.cnt   = cnt;

endmodule

[sv/cc20_serializer.sv]
// ----------------------------------------------------------------------------
// cc20_serializer
// holds one finished 64-byte block and hands it out as 64-bit words,
// masking the bytes past the requested count
// ----------------------------------------------------------------------------
module cc20_serializer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load_valid,
  output logic                       load_ready,
  input  cc20_pkg::state_t           load_blk,
  input  logic [cc20_pkg::CNT_W-1:0] load_cnt,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [63:0]                keystream_word,
  output logic [2:0]                 word_index,
  output logic [3:0]                 valid_bytes,
  output logic                       last_word
);

  logic                       busy;
  cc20_pkg::state_t           blk;
  logic [cc20_pkg::CNT_W-1:0] cnt;
  logic [2:0]                 idx;
  logic [cc20_pkg::CNT_W-1:0] rem;
  logic [63:0]                raw;
  logic                       beat;

  // bytes left from the current word on
  assign rem         = cnt - {1'b0, idx, 3'b000};
  assign last_word   = (rem <= 7'd8);
  assign valid_bytes = last_word ? rem[3:0] : 4'd8;
  assign raw         = {blk[{idx, 1'b1}], blk[{idx, 1'b0}]};

  // zero the bytes past the request
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      keystream_word[8*b +: 8] = (4'(b) < valid_bytes) ? raw[8*b +: 8] : 8'h00;
    end
  end

  assign out_valid  = busy;
  assign word_index = idx;
  assign beat       = busy && out_ready;
  assign load_ready = !busy || (beat && last_word);

  // word sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (beat) begin
      if (last_word) begin
        busy <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

  // block buffer
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      blk <= load_blk;
      cnt <= load_cnt;
    end
  end

  // a word that is not the last one is always full
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_word |-> valid_bytes == 4'd8)
    else $error("non-final word not full");

  // words of one block come out in order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    beat && !last_word |=> busy && word_index == $past(idx) + 3'd1)
    else $error("word index did not advance");

  // a fresh block starts at word zero
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    load_valid && load_ready |=> word_index == 3'd0 && busy)
    else $error("block load did not start at word zero");

  // a finished block frees the buffer unless a new one loads
  a_drain: assert property (@(posedge clk) disable iff (rst)
    beat && last_word && !load_valid |=> !busy)
    else $error("buffer still busy after last word");

endmodule

[sv/chacha20_keystream_block.sv]
// ----------------------------------------------------------------------------
// chacha20_keystream_block
// Each accepted beat (64-bit block counter, byte count) enters a pipeline of
// 4*DOUBLE_ROUNDS half-round stages plus one feed-forward add stage, then an
// output buffer. A new item can enter every cycle while the output buffer
// accepts blocks; the single 64-bit result port hands out ceil(byte_count/8)
// words per item, eight for a full block, and so limits the sustained rate.
// A byte count of zero is accepted and yields nothing; counts above 64 give a
// full block. Key and nonce registers must only change while no item is in
// flight.
// ----------------------------------------------------------------------------
module chacha20_keystream_block #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [63:0]                    block_counter,
  input  logic [6:0]                     byte_count,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [63:0]                    keystream_word,
  output logic [2:0]                     word_index,
  output logic [3:0]                     valid_bytes,
  output logic                           last_word
);

  localparam int STAGES = 4 * DOUBLE_ROUNDS;

  logic [63:0] key0, key1, key2, key3, nonce;

  cc20_pkg::meta_t  meta [STAGES+1];
  cc20_pkg::state_t st   [STAGES+1];

  logic             en;
  logic             ser_ready;
  logic             fin_valid;
  cc20_pkg::state_t fin_st;
  cc20_pkg::state_t fin_add;
  logic [cc20_pkg::CNT_W-1:0] fin_cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key0  <= '0;
      key1  <= '0;
      key2  <= '0;
      key3  <= '0;
      nonce <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cc20_pkg::REG_KEY_0: key0  <= cfg_data;
        cc20_pkg::REG_KEY_1: key1  <= cfg_data;
        cc20_pkg::REG_KEY_2: key2  <= cfg_data;
        cc20_pkg::REG_KEY_3: key3  <= cfg_data;
        cc20_pkg::REG_NONCE: nonce <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; holds only when the output buffer is full
  assign en       = !fin_valid || ser_ready;
  assign in_ready = en;

  // pipeline entry: zero counts drop out, large counts saturate
  assign meta[0].valid = in_valid && (byte_count != 7'd0);
  assign meta[0].ctr   = block_counter;
  assign meta[0].cnt   = (byte_count > cc20_pkg::BLOCK_BYTES) ? cc20_pkg::BLOCK_BYTES
                                                              : byte_count;
  assign st[0] = cc20_pkg::init_state(key0, key1, key2, key3, block_counter, nonce);

  // round stages: column first half, column second half, diagonal, diagonal
  for (genvar s = 0; s < STAGES; s++) begin : g_round
    cc20_round_stage #(
      .DIAG   (((s / 2) % 2) == 1),
      .SECOND ((s % 2) == 1)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_meta  (meta[s]),
      .in_st    (st[s]),
      .out_meta (meta[s+1]),
      .out_st   (st[s+1])
    );
  end

  // feed-forward add of the input state
  always_comb begin
    cc20_pkg::state_t init;
    init = cc20_pkg::init_state(key0, key1, key2, key3, meta[STAGES].ctr, nonce);
    for (int i = 0; i < 16; i++) begin
      fin_add[i] = st[STAGES][i] + init[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= meta[STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_st  <= fin_add;
      fin_cnt <= meta[STAGES].cnt;
    end
  end

  // word output buffer
  cc20_serializer u_ser (
    .clk            (clk),
    .rst            (rst),
    .load_valid     (fin_valid),
    .load_ready     (ser_ready),
    .load_blk       (fin_st),
    .load_cnt       (fin_cnt),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keystream_word (keystream_word),
    .word_index     (word_index),
    .valid_bytes    (valid_bytes),
    .last_word      (last_word)
  );

  // input stalls only behind a finished block waiting for the buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> fin_valid && out_valid)
    else $error("input stalled without a waiting block");

  // a held block keeps its place
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !ser_ready |=> fin_valid && $stable(fin_cnt))
    else $error("waiting block lost");

  // a zero byte count never enters the rounds
  a_zero_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && byte_count == 7'd0 |=> !meta[1].valid)
    else $error("empty request entered the pipeline");

endmodule
